>>> rtl/chm_pkg.sv
// Package: shared constants and types for the chained hash map
`timescale 1ns / 1ps
package chm_pkg;
  localparam int unsigned BucketsDef = 256;
  localparam int unsigned NodesDef   = 1024;
  localparam int unsigned DataWDef   = 32;
  localparam int unsigned KeyW       = 32;
  localparam int unsigned ValW       = 32;
  localparam int unsigned CfgW       = 9;
  localparam int unsigned ActW       = 2;
  localparam int unsigned HashMag    = 32;
  localparam logic [31:0] HashMult   = 32'h9CCF9319;

  typedef enum logic [1:0] {
    ActGet = 2'd0,
    ActPut = 2'd1,
    ActDel = 2'd2,
    ActNop = 2'd3
  } act_e;

  // hashed request passed from front to back
  typedef struct packed {
    logic [1:0]  act;
    logic [31:0] key;
    logic [63:0] val;
    logic [15:0] bucket;
  } req_t;
endpackage

>>> rtl/chained_hash_map_int_key_unit.sv
// Top level: chained hash map with multiplicative hash on signed keys
// Flow: the front multiplies the key, runs 32 restoring divide steps, writes its request queue and
// hands over; the back end reads the bucket head, then reads and compares chain nodes one by one.
// The front takes no new word until it is back in idle; the back end takes a request only when idle.
// A result word left unpopped stalls both.
// Reset: asynchronous, active low; bucket heads swept clear, bucket count 256.
`timescale 1ns / 1ps
module chained_hash_map_int_key_unit #(
  parameter int unsigned Buckets = chm_pkg::BucketsDef,
  parameter int unsigned Nodes   = chm_pkg::NodesDef,
  parameter int unsigned DataW   = chm_pkg::DataWDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  action_i,
  input  logic signed [31:0] key_i,
  input  logic [31:0] value_i,
  output logic        empty,
  input  logic        pop,
  output logic        found_o,
  output logic [31:0] value_out_o,
  output logic        full_res_o,
  input  logic        cfg_we_i,
  input  logic [8:0]  cfg_wdata_i
);
  logic          req_valid, req_ready;
  chm_pkg::req_t req;

  chm_front #(.Buckets(Buckets), .DataW(DataW)) u_front (
    .clk_i, .rst_ni, .push_i(push), .full_o(full), .action_i,
    .key_i(key_i), .value_i, .cfg_we_i, .cfg_wdata_i,
    .req_valid_o(req_valid), .req_ready_i(req_ready), .req_o(req));

  chm_back #(.Buckets(Buckets), .Nodes(Nodes), .DataW(DataW)) u_back (
    .clk_i, .rst_ni, .req_valid_i(req_valid), .req_ready_o(req_ready), .req_i(req),
    .empty_o(empty), .pop_i(pop), .found_o, .value_out_o, .full_res_o);
endmodule

>>> rtl/chm_ram.sv
// Generic single-write, single-read RAM with registered read data
`timescale 1ns / 1ps
module chm_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

>>> rtl/chm_front.sv
// Front end: accepts words, hashes the key over several cycles, queues requests
`timescale 1ns / 1ps
module chm_front #(
  parameter int unsigned Buckets = chm_pkg::BucketsDef,
  parameter int unsigned DataW   = chm_pkg::DataWDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  output logic                 full_o,
  input  logic [1:0]           action_i,
  input  logic [31:0]          key_i,
  input  logic [31:0]          value_i,
  input  logic                 cfg_we_i,
  input  logic [8:0]           cfg_wdata_i,
  output logic                 req_valid_o,
  input  logic                 req_ready_i,
  output chm_pkg::req_t        req_o
);
  typedef enum logic [1:0] {
    StIdle,
    StMul,
    StMod,
    StPush
  } state_e;

  state_e      state_q;
  logic [8:0]  cfg_q;
  logic [1:0]  act_q;
  logic [31:0] key_q;
  logic [63:0] val_q;
  logic [31:0] mag_q;
  logic [16:0] div_q;
  logic [16:0] rem_q;
  logic [5:0]  cnt_q;
  logic [31:0] prod;
  logic [31:0] mag_d;
  logic [16:0] rem_sh;
  logic [16:0] div_eff;
  logic [16:0] bc_sat;

  // two-entry request queue
  chm_pkg::req_t q_mem_q [2];
  logic          q_wp_q, q_rp_q;
  logic [1:0]    q_cnt_q;
  logic          q_push;
  logic          q_pop;

  assign prod  = key_q * chm_pkg::HashMult;
  assign mag_d = prod[31] ? (32'd0 - prod) : prod;
  assign rem_sh = {rem_q[15:0], mag_q[31]};

  always_comb begin
    bc_sat = {8'd0, cfg_q};
    if (cfg_q == 9'd0) bc_sat = 17'd1;
    if (bc_sat > 17'(Buckets)) bc_sat = 17'(Buckets);
    div_eff = bc_sat;
  end

  assign full_o      = (state_q != StIdle);
  assign q_push      = (state_q == StPush) && (q_cnt_q != 2'd2);
  assign q_pop       = req_valid_o && req_ready_i;
  assign req_valid_o = (q_cnt_q != 2'd0);
  assign req_o       = q_mem_q[q_rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cfg_q   <= 9'd256;
      cnt_q   <= '0;
      q_wp_q  <= 1'b0;
      q_rp_q  <= 1'b0;
      q_cnt_q <= '0;
    end else begin
      if (cfg_we_i) cfg_q <= cfg_wdata_i;
      unique case (state_q)
        StIdle: begin
          if (push_i) begin
            act_q   <= action_i;
            key_q   <= key_i;
            val_q   <= 64'(value_i) & ((DataW >= 64) ? '1 : ((64'd1 << DataW) - 64'd1));
            div_q   <= div_eff;
            state_q <= StMul;
          end
        end
        StMul: begin
          mag_q   <= mag_d;
          rem_q   <= '0;
          cnt_q   <= '0;
          state_q <= StMod;
        end
        StMod: begin
          // restoring division, one quotient bit a cycle
          mag_q <= {mag_q[30:0], 1'b0};
          rem_q <= (rem_sh >= div_q) ? (rem_sh - div_q) : rem_sh;
          cnt_q <= cnt_q + 6'd1;
          if (cnt_q == 6'd31) state_q <= StPush;
        end
        StPush: begin
          if (q_push) state_q <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
      if (q_push) begin
        q_mem_q[q_wp_q] <= '{act: act_q, key: key_q, val: val_q, bucket: rem_q[15:0]};
        q_wp_q <= ~q_wp_q;
      end
      if (q_pop) q_rp_q <= ~q_rp_q;
      q_cnt_q <= q_cnt_q + {1'b0, q_push} - {1'b0, q_pop};
    end
  end
endmodule

>>> rtl/chm_back.sv
// Back end: walks chains, updates the node pool, queues results
`timescale 1ns / 1ps
module chm_back #(
  parameter int unsigned Buckets = chm_pkg::BucketsDef,
  parameter int unsigned Nodes   = chm_pkg::NodesDef,
  parameter int unsigned DataW   = chm_pkg::DataWDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          req_valid_i,
  output logic          req_ready_o,
  input  chm_pkg::req_t req_i,
  output logic          empty_o,
  input  logic          pop_i,
  output logic          found_o,
  output logic [31:0]   value_out_o,
  output logic          full_res_o
);
  localparam int unsigned BW = (Buckets > 1) ? $clog2(Buckets) : 1;
  localparam int unsigned NW = $clog2(Nodes);
  localparam int unsigned LW = NW + 1;
  localparam int unsigned VW = DataW;
  localparam logic [LW-1:0] Nil = LW'(Nodes);

  typedef enum logic [3:0] {
    StClear, StIdle, StHead, StHeadW, StRead, StReadW, StCheck, StDo, StOut
  } state_e;

  state_e         state_q;
  logic [BW-1:0]  clr_q;
  logic [1:0]     act_q;
  logic [31:0]    key_q;
  logic [VW-1:0]  val_q;
  logic [BW-1:0]  bkt_q;
  logic [LW-1:0]  cur_q, prev_q;
  logic [LW-1:0]  cnt_free_q;
  logic [LW-1:0]  steps_q;
  logic [LW-1:0]  fs_init_q;
  logic           res_found_q, res_full_q;
  logic [31:0]    res_val_q;
  logic           out_v_q;
  logic           out_found_q, out_full_q;
  logic [31:0]    out_val_q;
  logic           out_load;

  // memory ports
  logic           hd_we;  logic [BW-1:0] hd_wa, hd_ra; logic [LW-1:0] hd_wd, hd_rd;
  logic           k_we;   logic [NW-1:0] n_wa, n_ra;   logic [31:0] k_wd, k_rd;
  logic           v_we;   logic [VW-1:0] v_wd, v_rd;
  logic           l_we;   logic [NW-1:0] l_wa;         logic [LW-1:0] l_wd, l_rd;
  logic           f_we;   logic [NW-1:0] f_wa, f_ra;   logic [NW-1:0] f_wd, f_rd;

  chm_ram #(.Width(LW), .Depth(Buckets)) u_heads (
    .clk_i, .we_i(hd_we), .waddr_i(hd_wa), .wdata_i(hd_wd), .raddr_i(hd_ra), .rdata_o(hd_rd));
  chm_ram #(.Width(32), .Depth(Nodes)) u_keys (
    .clk_i, .we_i(k_we), .waddr_i(n_wa), .wdata_i(k_wd), .raddr_i(n_ra), .rdata_o(k_rd));
  chm_ram #(.Width(VW), .Depth(Nodes)) u_vals (
    .clk_i, .we_i(v_we), .waddr_i(n_wa), .wdata_i(v_wd), .raddr_i(n_ra), .rdata_o(v_rd));
  chm_ram #(.Width(LW), .Depth(Nodes)) u_links (
    .clk_i, .we_i(l_we), .waddr_i(l_wa), .wdata_i(l_wd), .raddr_i(n_ra), .rdata_o(l_rd));
  chm_ram #(.Width(NW), .Depth(Nodes)) u_free (
    .clk_i, .we_i(f_we), .waddr_i(f_wa), .wdata_i(f_wd), .raddr_i(f_ra), .rdata_o(f_rd));

  logic hit, fs_init;
  assign hit = (k_rd == key_q);
  // free stack slots below the low-water mark were never written and hold Nodes-1-i
  assign fs_init = ({1'b0, f_ra} < fs_init_q);

  assign req_ready_o = (state_q == StIdle);
  assign empty_o     = !out_v_q;
  assign found_o     = out_found_q;
  assign value_out_o = out_val_q;
  assign full_res_o  = out_full_q;
  assign out_load    = (state_q == StOut) && (!out_v_q || pop_i);

  always_comb begin
    hd_we = 1'b0; hd_wa = bkt_q; hd_wd = Nil;
    hd_ra = bkt_q;
    k_we = 1'b0; v_we = 1'b0; l_we = 1'b0; f_we = 1'b0;
    n_wa = cur_q[NW-1:0]; l_wa = prev_q[NW-1:0];
    k_wd = key_q; v_wd = val_q; l_wd = l_rd;
    n_ra = cur_q[NW-1:0];
    f_wa = cnt_free_q[NW-1:0]; f_wd = cur_q[NW-1:0];
    f_ra = NW'(cnt_free_q - LW'(1));
    if (state_q == StClear) begin
      hd_we = 1'b1; hd_wa = clr_q;
    end
    if (state_q == StDo) begin
      if (cur_q != Nil) begin
        if (act_q == chm_pkg::ActPut) v_we = 1'b1;
        if (act_q == chm_pkg::ActDel) begin
          if (prev_q == Nil) begin hd_we = 1'b1; hd_wd = l_rd; end
          else l_we = 1'b1;
          f_we = (cnt_free_q < LW'(Nodes));
        end
      end else if (act_q == chm_pkg::ActPut && cnt_free_q != '0) begin
        n_wa = fs_init ? NW'(LW'(Nodes - 1) - (cnt_free_q - LW'(1))) : f_rd;
        k_we = 1'b1; v_we = 1'b1; l_we = 1'b1;
        l_wa = n_wa; l_wd = hd_rd;
        hd_we = 1'b1; hd_wd = {1'b0, n_wa};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StClear;
      clr_q       <= '0;
      cnt_free_q  <= LW'(Nodes);
      fs_init_q   <= LW'(Nodes);
      out_v_q     <= 1'b0;
      out_found_q <= 1'b0;
      out_val_q   <= '0;
      out_full_q  <= 1'b0;
    end else begin
      if (out_load) begin
        out_v_q     <= 1'b1;
        out_found_q <= res_found_q;
        out_val_q   <= res_val_q;
        out_full_q  <= res_full_q;
      end else if (out_v_q && pop_i) begin
        out_v_q <= 1'b0;
      end
      unique case (state_q)
        StClear: begin
          clr_q <= clr_q + BW'(1);
          if (clr_q == BW'(Buckets - 1)) state_q <= StIdle;
        end
        StIdle: begin
          if (req_valid_i) begin
            act_q <= req_i.act;
            key_q <= req_i.key;
            val_q <= req_i.val[VW-1:0];
            bkt_q <= req_i.bucket[BW-1:0];
            res_found_q <= 1'b0; res_full_q <= 1'b0; res_val_q <= '0;
            prev_q  <= Nil;
            steps_q <= '0;
            state_q <= (req_i.act == chm_pkg::ActNop) ? StOut : StHead;
          end
        end
        StHead:  state_q <= StHeadW;
        StHeadW: begin
          cur_q   <= hd_rd;
          state_q <= StRead;
        end
        StRead: state_q <= (cur_q == Nil) ? StDo : StReadW;
        StReadW: state_q <= StCheck;
        StCheck: begin
          if (hit) state_q <= StDo;
          else if (steps_q == LW'(Nodes - 1)) begin
            cur_q <= Nil; state_q <= StDo;
          end else begin
            prev_q  <= cur_q;
            cur_q   <= l_rd;
            steps_q <= steps_q + LW'(1);
            state_q <= StRead;
          end
        end
        StDo: begin
          if (cur_q != Nil) begin
            res_found_q <= 1'b1;
            if (act_q != chm_pkg::ActPut) res_val_q <= 32'(v_rd);
            if (act_q == chm_pkg::ActDel && cnt_free_q < LW'(Nodes)) begin
              cnt_free_q <= cnt_free_q + LW'(1);
            end
          end else if (act_q == chm_pkg::ActPut) begin
            if (cnt_free_q == '0) res_full_q <= 1'b1;
            else begin
              cnt_free_q <= cnt_free_q - LW'(1);
              if ((cnt_free_q - LW'(1)) < fs_init_q) fs_init_q <= cnt_free_q - LW'(1);
            end
          end
          state_q <= StOut;
        end
        StOut: begin
          if (out_load) state_q <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end
endmodule

>>> rtl/chm_checker.sv
// Port checker for the chained hash map, bound to the top level
`timescale 1ns / 1ps
module chm_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        push,
  input logic        full,
  input logic        empty,
  input logic        pop,
  input logic        found_o,
  input logic [31:0] value_out_o,
  input logic        full_res_o
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(value_out_o) && $stable(found_o)))
    else $error("result word changed while waiting");
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> !(found_o && full_res_o))
    else $error("found and full both set");
  a_nf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && full_res_o) |-> (value_out_o == 32'd0))
    else $error("full result carries data");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !full) |=> full)
    else $error("front accepted without going busy");
endmodule

bind chained_hash_map_int_key_unit chm_checker u_chm_checker (
  .clk_i, .rst_ni, .push, .full, .empty, .pop, .found_o, .value_out_o, .full_res_o);

>>> test/tb_chained_hash_map_int_key_unit.sv
// Testbench: randomised regression of the chained hash map against a behavioural map model
`timescale 1ns / 1ps
module tb_chained_hash_map_int_key_unit;
  localparam int unsigned NodeCnt   = 1024;
  localparam int unsigned BktMax    = 256;
  localparam int unsigned NilLink   = 1024;
  localparam int unsigned DrainWait = 4000;
  localparam int unsigned IdleLimit = 40000;

  typedef struct packed {
    logic        found;
    logic [31:0] val;
    logic        full;
  } map_res_t;

  // map model: chains, node pool and free stack
  class map_scoreboard;
    int unsigned bkt_cnt;
    int unsigned heads[BktMax];
    logic [31:0] nkey[NodeCnt];
    logic [31:0] nval[NodeCnt];
    int unsigned nlink[NodeCnt];
    int unsigned free_stk[NodeCnt];
    int unsigned free_cnt;
    map_res_t    pending[$];
    int unsigned errors;

    function void clear();
      bkt_cnt = 256;
      foreach (heads[i]) heads[i] = NilLink;
      for (int i = 0; i < NodeCnt; i++) begin
        nlink[i] = NilLink;
        free_stk[i] = NodeCnt - 1 - i;
      end
      free_cnt = NodeCnt;
      errors = 0;
    endfunction

    function int unsigned bucket_of(logic [31:0] k);
      logic [31:0] p, mag;
      int unsigned n;
      n = bkt_cnt == 0 ? 1 : (bkt_cnt > BktMax ? BktMax : bkt_cnt);
      p = k * chm_pkg::HashMult;
      mag = p[31] ? -p : p;
      return mag % n;
    endfunction

    function void note_word(chm_pkg::act_e a, logic [31:0] k, logic [31:0] v);
      map_res_t r;
      int unsigned h, cur, prev, steps, nd;
      r = '0;
      if (a != chm_pkg::ActNop) begin
        h = bucket_of(k);
        cur = heads[h];
        prev = NilLink;
        steps = 0;
        while (cur < NilLink && steps < NodeCnt && nkey[cur] != k) begin
          prev = cur;
          cur = nlink[cur];
          steps++;
        end
        if (steps >= NodeCnt) cur = NilLink;
        if (cur != NilLink) begin
          r.found = 1'b1;
          if (a == chm_pkg::ActGet) r.val = nval[cur];
          else if (a == chm_pkg::ActPut) nval[cur] = v;
          else begin
            r.val = nval[cur];
            if (prev == NilLink) heads[h] = nlink[cur];
            else nlink[prev] = nlink[cur];
            if (free_cnt < NodeCnt) begin
              free_stk[free_cnt] = cur;
              free_cnt++;
            end
          end
        end else if (a == chm_pkg::ActPut) begin
          if (free_cnt == 0) r.full = 1'b1;
          else begin
            free_cnt--;
            nd = free_stk[free_cnt];
            nkey[nd] = k;
            nval[nd] = v;
            nlink[nd] = heads[h];
            heads[h] = nd;
          end
        end
      end
      pending.push_back(r);
    endfunction

    function void check_word(map_res_t got);
      map_res_t exp;
      if (pending.size() == 0) begin
        $display("%0t: unexpected word found=%0b val=%h full=%0b", $time,
                 got.found, got.val, got.full);
        errors++;
        return;
      end
      exp = pending.pop_front();
      if (got.found !== exp.found) begin
        $display("%0t: found exp %0b got %0b", $time, exp.found, got.found);
        errors++;
      end
      if (got.val !== exp.val) begin
        $display("%0t: value_out exp %h got %h", $time, exp.val, got.val);
        errors++;
      end
      if (got.full !== exp.full) begin
        $display("%0t: full_res exp %0b got %0b", $time, exp.full, got.full);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i, rst_ni;
  logic        push, full, empty, pop;
  logic [1:0]  action_i;
  logic signed [31:0] key_i;
  logic [31:0] value_i;
  logic        found_o, full_res_o;
  logic [31:0] value_out_o;
  logic        cfg_we_i;
  logic [8:0]  cfg_wdata_i;

  chained_hash_map_int_key_unit dut (
    .clk_i, .rst_ni, .push, .full, .action_i, .key_i, .value_i,
    .empty, .pop, .found_o, .value_out_o, .full_res_o, .cfg_we_i, .cfg_wdata_i
  );

  map_scoreboard sb;
  int unsigned   idle_pct;    // chance of a gap on either side
  bit            rx_hold;     // receiver held off
  int unsigned   idle_cycles;
  logic [31:0]   keys_used[$];

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // watchdog and acceptance bookkeeping
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((push && !full) || (pop && !empty)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (push && !full) sb.note_word(chm_pkg::act_e'(action_i), key_i, value_i);
      if (pop && !empty) sb.check_word('{found_o, value_out_o, full_res_o});
      if (idle_cycles >= IdleLimit) begin
        $display("chained_hash_map_int_key_unit regression: fail");
        $finish;
      end
    end
  end

  // receiver
  always @(posedge clk_i) begin
    if (!rst_ni) pop <= 1'b0;
    else pop <= !rx_hold && ($urandom_range(99) >= idle_pct);
  end

  // push stays high after the word is taken; the next word or an idle gap replaces it
  task automatic send_word(chm_pkg::act_e a, logic [31:0] k, logic [31:0] v);
    while ($urandom_range(99) < idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push <= 1'b1;
    action_i <= a;
    key_i <= k;
    value_i <= v;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
  endtask

  task automatic drain();
    push <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  task automatic write_bucket_count(logic [8:0] n);
    drain();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= n;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.bkt_cnt = n;
  endtask

  function automatic logic [31:0] pick_key();
    if (keys_used.size() != 0 && $urandom_range(99) < 60)
      return keys_used[$urandom_range(keys_used.size() - 1)];
    pick_key = $urandom();
    if ($urandom_range(3) == 0) pick_key = $urandom_range(15);
    keys_used.push_back(pick_key);
    if (keys_used.size() > 64) void'(keys_used.pop_front());
  endfunction

  task automatic random_phase(int unsigned n);
    int unsigned r;
    chm_pkg::act_e a;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      a = r < 40 ? chm_pkg::ActPut :
          (r < 70 ? chm_pkg::ActGet : (r < 97 ? chm_pkg::ActDel : chm_pkg::ActNop));
      send_word(a, pick_key(), $urandom());
    end
  endtask

  initial begin
    logic [31:0] dir_keys[6];
    sb = new();
    sb.clear();
    rst_ni = 1'b0;
    push = 1'b0;
    action_i = chm_pkg::ActGet;
    key_i = '0;
    value_i = '0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    idle_pct = 0;
    rx_hold = 1'b0;
    idle_cycles = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extremes, all actions, no-op code
    dir_keys = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'h1, 32'h5555_AAAA};
    foreach (dir_keys[i]) send_word(chm_pkg::ActGet, dir_keys[i], 32'hFFFF_FFFF);
    foreach (dir_keys[i]) send_word(chm_pkg::ActPut, dir_keys[i], ~dir_keys[i]);
    send_word(chm_pkg::ActPut, 32'h8000_0000, 32'h0);
    send_word(chm_pkg::ActNop, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    foreach (dir_keys[i]) send_word(chm_pkg::ActGet, dir_keys[i], 32'h0);
    send_word(chm_pkg::ActDel, 32'h7FFF_FFFF, 32'h0);
    send_word(chm_pkg::ActDel, 32'h7FFF_FFFF, 32'h0);
    send_word(chm_pkg::ActGet, 32'h7FFF_FFFF, 32'h0);

    // long run with no gaps, receiver held off so the input stalls
    rx_hold = 1'b1;
    fork
      begin
        repeat (3000) @(posedge clk_i);
        rx_hold = 1'b0;
      end
      random_phase(120);
    join

    idle_pct = 35;
    random_phase(200);

    // one bucket: long chains
    write_bucket_count(9'd1);
    random_phase(120);
    write_bucket_count(9'd0);
    random_phase(40);
    // remapping leaves stale entries in old chains
    write_bucket_count(9'd511);
    random_phase(100);
    write_bucket_count(9'd7);
    random_phase(100);

    // fill the pool to exhaustion, then hit the full case and free some
    write_bucket_count(9'd256);
    for (int i = 0; i < NodeCnt + 8; i++) send_word(chm_pkg::ActPut, $urandom(), $urandom());
    for (int i = 0; i < 40; i++) send_word(chm_pkg::ActPut, pick_key(), $urandom());
    random_phase(75);

    write_bucket_count(9'd256);
    random_phase(50);

    drain();
    repeat (DrainWait) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("chained_hash_map_int_key_unit regression: pass");
    else
      $display("chained_hash_map_int_key_unit regression: fail");
    $finish;
  end
endmodule
